// File: src/cmr_pkg.sv
package cmr_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned SUM_W   = 2 * FIELD_W;
    localparam int unsigned REM_W   = FIELD_W + 3;
    localparam int unsigned STEPS   = FIELD_W;
    localparam int unsigned CNT_W   = $clog2(STEPS);
    localparam int unsigned SEL_W   = 2;
    localparam int unsigned IDX_W   = 2;

    // register indexes
    localparam logic [IDX_W-1:0] CFG_RANGE_SELECT    = 2'd0;
    localparam logic [IDX_W-1:0] CFG_UPPER_THRESHOLD = 2'd1;
    localparam logic [IDX_W-1:0] CFG_LOWER_THRESHOLD = 2'd2;

    // range codes
    localparam logic [SEL_W-1:0] RANGE_LOW  = 2'd0;
    localparam logic [SEL_W-1:0] RANGE_HIGH = 2'd1;

    localparam logic [SEL_W-1:0]   RST_RANGE_SELECT    = RANGE_HIGH;
    localparam logic [FIELD_W-1:0] RST_UPPER_THRESHOLD = 16'd15000;
    localparam logic [FIELD_W-1:0] RST_LOWER_THRESHOLD = 16'd2500;

    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_stat;

endpackage

// File: src/complex_magnitude_range_check.sv
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+---------------------------
// command  | start, busy, i_real_part, i_imag_part         | start && !busy at edge
// result   | o_valid, o_magnitude, o_want_*, o_mode_error  | o_valid, one cycle
// config   | i_cfg_we, i_cfg_idx, i_cfg_data               | i_cfg_we at edge
//
// Each item runs 16 serial multiply steps and then 16 square-root steps, with
// handoffs between; a new transfer is not taken until the item before is done.
// The result strobe rises the cycle busy falls; a new start may coincide.
// Synchronous active-low reset restores range high, thresholds 15000/2500.
// The result is shown for one cycle only; the receiver has no stall.
module complex_magnitude_range_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [cmr_pkg::FIELD_W-1:0] i_real_part,
    input  logic signed [cmr_pkg::FIELD_W-1:0] i_imag_part,
    input  logic                               i_cfg_we,
    input  logic [cmr_pkg::IDX_W-1:0]          i_cfg_idx,
    input  logic [cmr_pkg::FIELD_W-1:0]        i_cfg_data,
    output logic                               o_valid,
    output logic [cmr_pkg::FIELD_W-1:0]        o_magnitude,
    output logic                               o_want_high_range,
    output logic                               o_want_low_range,
    output logic                               o_mode_error
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SQR  = 3'b010,
        ST_ROOT = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [cmr_pkg::SEL_W-1:0]   r_range_select;
    logic [cmr_pkg::FIELD_W-1:0] r_upper_threshold, r_lower_threshold;

    logic                        r_valid;
    logic [cmr_pkg::FIELD_W-1:0] r_magnitude;
    logic                        r_want_high, r_want_low, r_mode_error;

    logic                        w_accept, w_root_start, w_mode_ok;
    logic [cmr_pkg::SUM_W-1:0]   w_sum;
    logic [cmr_pkg::FIELD_W-1:0] w_root;
    cmr_pkg::t_unit_stat         w_sq_stat, w_rt_stat;

    assign busy         = (r_state != ST_IDLE);
    assign w_accept     = start && !busy;
    assign w_root_start = (r_state == ST_SQR) && w_sq_stat.done;
    assign w_mode_ok    = (r_range_select == cmr_pkg::RANGE_LOW)
                       || (r_range_select == cmr_pkg::RANGE_HIGH);

    cmr_sqsum u_sqsum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_accept),
        .i_real_part (i_real_part),
        .i_imag_part (i_imag_part),
        .o_sum       (w_sum),
        .o_stat      (w_sq_stat)
    );

    cmr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_sum),
        .o_root     (w_root),
        .o_stat     (w_rt_stat)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SQR;
            end
            ST_SQR: begin
                if (w_sq_stat.done) n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (w_rt_stat.done) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ST_IDLE;
            r_valid           <= 1'b0;
            r_range_select    <= cmr_pkg::RST_RANGE_SELECT;
            r_upper_threshold <= cmr_pkg::RST_UPPER_THRESHOLD;
            r_lower_threshold <= cmr_pkg::RST_LOWER_THRESHOLD;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_ROOT) && w_rt_stat.done;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    cmr_pkg::CFG_RANGE_SELECT:
                        r_range_select <= i_cfg_data[cmr_pkg::SEL_W-1:0];
                    cmr_pkg::CFG_UPPER_THRESHOLD: r_upper_threshold <= i_cfg_data;
                    cmr_pkg::CFG_LOWER_THRESHOLD: r_lower_threshold <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_ROOT) && w_rt_stat.done) begin
            r_magnitude  <= w_mode_ok ? w_root : '0;
            r_want_high  <= (r_range_select == cmr_pkg::RANGE_LOW)
                         && (w_root > r_upper_threshold);
            r_want_low   <= (r_range_select == cmr_pkg::RANGE_HIGH)
                         && (w_root < r_lower_threshold);
            r_mode_error <= !w_mode_ok;
        end
    end

    assign o_valid           = r_valid;
    assign o_magnitude       = r_magnitude;
    assign o_want_high_range = r_want_high;
    assign o_want_low_range  = r_want_low;
    assign o_mode_error      = r_mode_error;

endmodule

// File: src/cmr_sqsum.sv
// Bit-serial re^2 + im^2: one multiplier bit of each square per cycle,
// both partial products added into the upper half, then shifted right.
module cmr_sqsum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [cmr_pkg::FIELD_W-1:0] i_real_part,
    input  logic signed [cmr_pkg::FIELD_W-1:0] i_imag_part,
    output logic [cmr_pkg::SUM_W-1:0]      o_sum,
    output cmr_pkg::t_unit_stat            o_stat
);

    logic [cmr_pkg::FIELD_W-1:0] r_ma, r_mi, r_qa, r_qi, r_lo;
    logic [cmr_pkg::FIELD_W:0]   r_hi;
    logic [cmr_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_busy, r_done;

    logic [cmr_pkg::FIELD_W-1:0] w_abs_re, w_abs_im;
    logic [cmr_pkg::FIELD_W+1:0] w_acc;

    assign w_abs_re = i_real_part[cmr_pkg::FIELD_W-1] ? (~i_real_part + 1'b1) : i_real_part;
    assign w_abs_im = i_imag_part[cmr_pkg::FIELD_W-1] ? (~i_imag_part + 1'b1) : i_imag_part;

    assign w_acc = {1'b0, r_hi}
                 + {2'b00, (r_qa[0] ? r_ma : '0)}
                 + {2'b00, (r_qi[0] ? r_mi : '0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cmr_pkg::LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_ma <= w_abs_re;
            r_mi <= w_abs_im;
            r_qa <= w_abs_re;
            r_qi <= w_abs_im;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_qa <= r_qa >> 1;
            r_qi <= r_qi >> 1;
            r_hi <= w_acc[cmr_pkg::FIELD_W+1:1];
            r_lo <= {w_acc[0], r_lo[cmr_pkg::FIELD_W-1:1]};
        end
    end

    // sum never exceeds 2^31, so the top bit of r_hi is always zero here
    assign o_sum       = {r_hi[cmr_pkg::FIELD_W-1:0], r_lo};
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: src/cmr_isqrt.sv
// Restoring square root, two radicand bits in and one root bit out per cycle.
module cmr_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [cmr_pkg::SUM_W-1:0]    i_radicand,
    output logic [cmr_pkg::FIELD_W-1:0]  o_root,
    output cmr_pkg::t_unit_stat          o_stat
);

    logic [cmr_pkg::SUM_W-1:0]   r_x;
    logic [cmr_pkg::REM_W-1:0]   r_rem;
    logic [cmr_pkg::FIELD_W-1:0] r_root;
    logic [cmr_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_busy, r_done;

    logic [cmr_pkg::REM_W-1:0] w_shift, w_trial;
    logic                      w_ge;

    // remainder stays below 2^17 between steps
    assign w_shift = {r_rem[cmr_pkg::REM_W-3:0], r_x[cmr_pkg::SUM_W-1 -: 2]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_shift >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == cmr_pkg::LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x    <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[cmr_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_shift - w_trial) : w_shift;
            r_root <= {r_root[cmr_pkg::FIELD_W-2:0], w_ge};
        end
    end

    assign o_root      = r_root;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: src/cmr_checker.sv
module cmr_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [cmr_pkg::FIELD_W-1:0] i_real_part,
    input logic signed [cmr_pkg::FIELD_W-1:0] i_imag_part,
    input logic                               i_cfg_we,
    input logic [cmr_pkg::IDX_W-1:0]          i_cfg_idx,
    input logic [cmr_pkg::FIELD_W-1:0]        i_cfg_data,
    input logic                               o_valid,
    input logic [cmr_pkg::FIELD_W-1:0]        o_magnitude,
    input logic                               o_want_high_range,
    input logic                               o_want_low_range,
    input logic                               o_mode_error
);

    // a transfer always starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command transfer");

    // one strobe per item, never back to back
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_mode_error) |->
            (o_magnitude == '0) && !o_want_high_range && !o_want_low_range)
        else $error("mode error with nonzero result");

    a_req_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_want_high_range && o_want_low_range))
        else $error("both range requests raised");

endmodule

bind complex_magnitude_range_check cmr_checker u_cmr_checker (.*);
